/* rtl/tile_element_delay_quantizer_macros.svh */
// Assertion macros for the tile element delay quantizer RTL.
// Used by tedq_step_pick and tile_element_delay_quantizer; expects clk and rst_n in scope.
`ifndef TILE_ELEMENT_DELAY_QUANTIZER_MACROS_SVH
`define TILE_ELEMENT_DELAY_QUANTIZER_MACROS_SVH

`ifndef SYNTHESIS
`define TEDQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tedq: same-cycle check failed");
`define TEDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tedq: next-cycle check failed");
`else
`define TEDQ_ASSERT_SAME(label, ante, cons)
`define TEDQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/tedq_pkg.sv */
// Shared types and constants for the tile element delay quantizer.
// No dependencies; used by every module of the block.
package tedq_pkg;

  localparam int STEP_COUNT_DEF    = 32;
  localparam int SEARCH_RADIUS_DEF = 2;

  localparam int DIR_W       = 16;
  localparam int ENTRY_W     = 16;
  localparam int IDX_W       = 5;
  localparam int CODE_W      = 8;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 16;

  localparam int DOT_W   = 34;
  localparam int PSK_W   = 19;
  localparam int MUL_W   = DOT_W + PSK_W;
  localparam int DELAY_W = 52;
  localparam int DIST_W  = DELAY_W + 1;

  localparam int PS_PER_MM_Q16 = 218605;
  localparam int FRAC_BITS     = 31;
  localparam int HALF_NS_PS    = 500;
  localparam int HI_W          = DELAY_W - FRAC_BITS;

  // floor(x / 500) = ((x >> 2) * 8389) >> 20 for 0 <= x < 2^15
  localparam int QUOT_MSB    = 14;
  localparam int QUOT_LSB    = 2;
  localparam int DIV_RECIP   = 8389;
  localparam int DIV_SHIFT   = 20;
  localparam int QP_W        = 27;

  localparam int MAX_STEP   = 31;
  localparam int CODE_BASE  = 1 << 7;
  localparam int CODE_SCALE = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUANT = 1'b1
  } opcode_t;

  typedef struct packed {
    logic               is_load;
    logic [IDX_W-1:0]   entry_index;
    logic [ENTRY_W-1:0] entry_delay_ps;
  } load_side_t;

  typedef struct packed {
    load_side_t                 side;
    logic signed [DELAY_W-1:0]  delay;
  } calc_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  step_index;
    logic [CODE_W-1:0] setting_code;
    logic              was_clamped;
  } step_result_t;

endpackage

/* rtl/tedq_delay_calc.sv */
// Four-stage delay datapath: products, dot sum, ps scaling, mean offset.
// Depends on tedq_pkg.
module tedq_delay_calc (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  tedq_pkg::opcode_t                      in_opcode,
  input  logic [tedq_pkg::IDX_W-1:0]             entry_index,
  input  logic [tedq_pkg::ENTRY_W-1:0]           entry_delay_ps,
  input  logic signed [tedq_pkg::DIR_W-1:0]      dir_x,
  input  logic signed [tedq_pkg::DIR_W-1:0]      dir_y,
  input  logic signed [tedq_pkg::DIR_W-1:0]      dir_z,
  input  logic signed [tedq_pkg::DIR_W-1:0]      pos_x,
  input  logic signed [tedq_pkg::DIR_W-1:0]      pos_y,
  input  logic signed [tedq_pkg::DIR_W-1:0]      pos_z,
  input  logic [tedq_pkg::ENTRY_W-1:0]           mean_delay_ps,
  output logic                                   calc_valid,
  output tedq_pkg::calc_item_t                   calc_item
);

  localparam int PROD_W = 2 * tedq_pkg::DIR_W;
  localparam logic signed [tedq_pkg::PSK_W-1:0] PS_K =
    tedq_pkg::PSK_W'(tedq_pkg::PS_PER_MM_Q16);

  logic                                     s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  tedq_pkg::load_side_t                     s1_side_r, s2_side_r, s3_side_r, s4_side_r;
  tedq_pkg::load_side_t                     side_nxt;
  logic signed [PROD_W-1:0]                 px_r, py_r, pz_r;
  logic signed [PROD_W-1:0]                 px_nxt, py_nxt, pz_nxt;
  logic signed [tedq_pkg::DOT_W-1:0]        dot_r, dot_nxt;
  logic signed [tedq_pkg::MUL_W-1:0]        prod_r, prod_nxt;
  logic signed [tedq_pkg::DELAY_W-1:0]      delay_r, delay_nxt;

  always_comb begin
    side_nxt.is_load        = (in_opcode == tedq_pkg::OP_LOAD);
    side_nxt.entry_index    = entry_index;
    side_nxt.entry_delay_ps = entry_delay_ps;
    px_nxt    = dir_x * pos_x;
    py_nxt    = dir_y * pos_y;
    pz_nxt    = dir_z * pos_z;
    dot_nxt   = tedq_pkg::DOT_W'(px_r) + tedq_pkg::DOT_W'(py_r) + tedq_pkg::DOT_W'(pz_r);
    prod_nxt  = dot_r * PS_K;
    delay_nxt = tedq_pkg::DELAY_W'(prod_r)
              + tedq_pkg::DELAY_W'(signed'({1'b0, mean_delay_ps,
                                            {tedq_pkg::FRAC_BITS{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= side_nxt;
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      pz_r      <= pz_nxt;
      s2_side_r <= s1_side_r;
      dot_r     <= dot_nxt;
      s3_side_r <= s2_side_r;
      prod_r    <= prod_nxt;
      s4_side_r <= s3_side_r;
      delay_r   <= delay_nxt;
    end
  end

  assign calc_valid      = s4_valid_r;
  assign calc_item.side  = s4_side_r;
  assign calc_item.delay = delay_r;

endmodule

/* rtl/tedq_step_pick.sv */
// Step selection pipeline: approximate step, banked step table, distances, winner, encode.
// Depends on tedq_pkg and tile_element_delay_quantizer_macros.svh.
`include "tile_element_delay_quantizer_macros.svh"

module tedq_step_pick #(
  parameter int STEP_COUNT    = tedq_pkg::STEP_COUNT_DEF,
  parameter int SEARCH_RADIUS = tedq_pkg::SEARCH_RADIUS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    calc_valid,
  input  tedq_pkg::calc_item_t    calc_item,
  output logic                    res_valid,
  output tedq_pkg::step_result_t  res_item
);

  localparam int AW  = $clog2(STEP_COUNT);
  localparam int KW  = ((AW > tedq_pkg::IDX_W) ? AW : tedq_pkg::IDX_W) + 2;
  localparam int NW  = 2 * SEARCH_RADIUS + 1;
  localparam int LB  = $clog2(NW);
  localparam int NB  = 1 << LB;
  localparam int BD0 = (STEP_COUNT + NB - 1) / NB;
  localparam int AB  = (BD0 > 1) ? $clog2(BD0) : 1;
  localparam int BD  = 1 << AB;
  localparam int HI_W   = tedq_pkg::HI_W;
  localparam int DW     = tedq_pkg::DELAY_W;
  localparam int DIST_W = tedq_pkg::DIST_W;
  localparam int FB     = tedq_pkg::FRAC_BITS;
  localparam logic signed [HI_W-1:0] NEG_STEP = HI_W'(-tedq_pkg::HALF_NS_PS);
  localparam logic signed [HI_W-1:0] POS_LIM  = HI_W'(STEP_COUNT * tedq_pkg::HALF_NS_PS);
  localparam logic [LB-1:0] CENTER_OFF = LB'(SEARCH_RADIUS);

  // stage A: approximate step
  logic signed [HI_W-1:0]         hi;
  logic [tedq_pkg::QP_W-1:0]      qp;
  logic [AW-1:0]                  approx_nxt;
  logic                           clamp_nxt;
  logic                           a_valid_r;
  tedq_pkg::load_side_t           a_side_r;
  logic signed [DW-1:0]           a_delay_r;
  logic [AW-1:0]                  a_approx_r;
  logic                           a_clamp_r;

  // stage B: table banks
  logic [tedq_pkg::ENTRY_W-1:0]   bank_mem [NB][BD];
  logic [KW-1:0]                  a_base;
  logic [LB-1:0]                  b_off_nxt [NB];
  logic [KW-1:0]                  kb [NB];
  logic [AB-1:0]                  rd_addr [NB];
  logic [NB-1:0]                  cand_nxt;
  logic [KW-1:0]                  wk;
  logic                           wr_en;
  logic [LB-1:0]                  wr_bank;
  logic [AB-1:0]                  wr_addr;
  logic [tedq_pkg::ENTRY_W-1:0]   rd_data_r [NB];
  logic [LB-1:0]                  b_off_r [NB];
  logic [NB-1:0]                  b_cand_r;
  logic                           b_valid_r;
  logic signed [DW-1:0]           b_delay_r;
  logic [AW-1:0]                  b_approx_r;
  logic                           b_clamp_r;

  // stage C: distances
  logic signed [DIST_W-1:0]       diff [NB];
  logic [DIST_W-2:0]              dist_nxt [NB];
  logic [DIST_W-2:0]              c_dist_r [NB];
  logic [LB-1:0]                  c_off_r [NB];
  logic [NB-1:0]                  c_cand_r;
  logic                           c_valid_r;
  logic [AW-1:0]                  c_approx_r;
  logic                           c_clamp_r;

  // stage D: winner
  logic [NB-1:0]                  win_nxt;
  logic [NB-1:0]                  d_win_r;
  logic [LB-1:0]                  d_off_r [NB];
  logic                           d_valid_r;
  logic [AW-1:0]                  d_approx_r;
  logic                           d_clamp_r;

  // stage E: encode
  logic [LB-1:0]                  sel_off;
  logic [KW-1:0]                  k_e;
  tedq_pkg::step_result_t         res_nxt;
  tedq_pkg::step_result_t         res_r;
  logic                           res_valid_r;

  always_comb begin
    hi = calc_item.delay[DW-1:FB];
    qp = tedq_pkg::QP_W'(hi[tedq_pkg::QUOT_MSB:tedq_pkg::QUOT_LSB])
       * tedq_pkg::QP_W'(tedq_pkg::DIV_RECIP);
    approx_nxt = '0;
    clamp_nxt  = 1'b0;
    if (hi < NEG_STEP || (hi == NEG_STEP && calc_item.delay[FB-1:0] == '0)) begin
      clamp_nxt = 1'b1;
    end else if (hi >= POS_LIM) begin
      approx_nxt = AW'(STEP_COUNT - 1);
      clamp_nxt  = 1'b1;
    end else if (!hi[HI_W-1]) begin
      approx_nxt = qp[tedq_pkg::DIV_SHIFT +: AW];
    end
  end

  always_comb begin
    a_base = KW'(a_approx_r) - KW'(SEARCH_RADIUS);
    for (int b = 0; b < NB; b++) begin
      b_off_nxt[b] = LB'(b) - a_base[LB-1:0];
      kb[b]        = a_base + KW'(b_off_nxt[b]);
      rd_addr[b]   = kb[b][LB +: AB];
      cand_nxt[b]  = !kb[b][KW-1] && (kb[b] < KW'(STEP_COUNT)) && (b_off_nxt[b] < LB'(NW));
    end
    wk      = KW'(a_side_r.entry_index);
    wr_bank = wk[LB-1:0];
    wr_addr = wk[LB +: AB];
    wr_en   = en && a_valid_r && a_side_r.is_load && (wk < KW'(STEP_COUNT));
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NB; b++) begin
      if (wr_en && wr_bank == LB'(b)) begin
        bank_mem[b][wr_addr] <= a_side_r.entry_delay_ps;
      end
      if (en) begin
        rd_data_r[b] <= bank_mem[b][rd_addr[b]];
      end
    end
  end

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      diff[b] = DIST_W'(b_delay_r)
              - DIST_W'(signed'({1'b0, rd_data_r[b], {FB{1'b0}}}));
      dist_nxt[b] = diff[b][DIST_W-1] ? (DIST_W-1)'(-diff[b]) : (DIST_W-1)'(diff[b]);
    end
  end

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      win_nxt[i] = c_cand_r[i];
      for (int j = 0; j < NB; j++) begin
        if (j != i && c_cand_r[j]) begin
          if (c_dist_r[j] < c_dist_r[i]) begin
            win_nxt[i] = 1'b0;
          end else if (c_dist_r[j] == c_dist_r[i]) begin
            if (c_off_r[j] == CENTER_OFF ||
                (c_off_r[i] != CENTER_OFF && c_off_r[j] < c_off_r[i])) begin
              win_nxt[i] = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    sel_off = '0;
    for (int b = 0; b < NB; b++) begin
      sel_off = sel_off | (d_win_r[b] ? d_off_r[b] : '0);
    end
    k_e = KW'(d_approx_r) - KW'(SEARCH_RADIUS) + KW'(sel_off);
    res_nxt.was_clamped = d_clamp_r;
    if (k_e > KW'(tedq_pkg::MAX_STEP)) begin
      res_nxt.step_index  = tedq_pkg::IDX_W'(tedq_pkg::MAX_STEP);
      res_nxt.was_clamped = 1'b1;
    end else begin
      res_nxt.step_index = k_e[tedq_pkg::IDX_W-1:0];
    end
    res_nxt.setting_code = tedq_pkg::CODE_W'(tedq_pkg::CODE_BASE)
                         + tedq_pkg::CODE_W'(res_nxt.step_index)
                         * tedq_pkg::CODE_W'(tedq_pkg::CODE_SCALE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= calc_valid;
      // drop loads once the table write is done
      b_valid_r   <= a_valid_r && !a_side_r.is_load;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      res_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r   <= calc_item.side;
      a_delay_r  <= calc_item.delay;
      a_approx_r <= approx_nxt;
      a_clamp_r  <= clamp_nxt;
      b_off_r    <= b_off_nxt;
      b_cand_r   <= cand_nxt;
      b_delay_r  <= a_delay_r;
      b_approx_r <= a_approx_r;
      b_clamp_r  <= a_clamp_r;
      c_dist_r   <= dist_nxt;
      c_off_r    <= b_off_r;
      c_cand_r   <= b_cand_r;
      c_approx_r <= b_approx_r;
      c_clamp_r  <= b_clamp_r;
      d_win_r    <= win_nxt;
      d_off_r    <= c_off_r;
      d_approx_r <= c_approx_r;
      d_clamp_r  <= c_clamp_r;
      res_r      <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_item  = res_r;

  `TEDQ_ASSERT_SAME(a_center_in_window, c_valid_r, c_cand_r != '0)
  `TEDQ_ASSERT_SAME(a_single_winner, d_valid_r, $onehot(d_win_r))
  `TEDQ_ASSERT_NEXT(a_winner_moves, en && d_valid_r, res_valid_r)

endmodule

/* rtl/tile_element_delay_quantizer.sv */
// Pipeline: ten register stages from products through the output register.
// Throughput: one transaction per cycle while in_tready is high; loads write the step
// table and give no result.
// in_tready drops only while the output skid register is full.
// Reset (rst_n low, synchronous) clears all valid bits and mean_delay_ps; the step table
// holds undefined values until loaded.
`include "tile_element_delay_quantizer_macros.svh"

module tile_element_delay_quantizer #(
  parameter int STEP_COUNT    = tedq_pkg::STEP_COUNT_DEF,
  parameter int SEARCH_RADIUS = tedq_pkg::SEARCH_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // entry_index[4:0], entry_delay_ps[20:5], dir_x[36:21], dir_y[52:37], dir_z[68:53],
  // pos_x[84:69], pos_y[100:85], pos_z[116:101], zero pad[119:117]
  input  logic [tedq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // step_index[4:0], setting_code[12:5], zero pad[15:13]
  output logic [tedq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // was_clamped[0]
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tedq_pkg::ENTRY_W-1:0]        cfg_data
);

  logic                            en;
  logic [tedq_pkg::ENTRY_W-1:0]    mean_delay_r;
  logic                            calc_valid;
  tedq_pkg::calc_item_t            calc_item;
  logic                            res_valid;
  tedq_pkg::step_result_t          res_item;
  logic                            out_valid_r, out_valid_nxt;
  logic                            skid_valid_r, skid_valid_nxt;
  tedq_pkg::step_result_t          out_r, out_nxt;
  tedq_pkg::step_result_t          skid_r, skid_nxt;
  logic                            out_take;

  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_delay_r <= '0;
    end else if (cfg_valid) begin
      mean_delay_r <= cfg_data;
    end
  end

  tedq_delay_calc u_delay_calc (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_tvalid),
    .in_opcode      (tedq_pkg::opcode_t'(in_tuser)),
    .entry_index    (in_tdata[4:0]),
    .entry_delay_ps (in_tdata[20:5]),
    .dir_x          (signed'(in_tdata[36:21])),
    .dir_y          (signed'(in_tdata[52:37])),
    .dir_z          (signed'(in_tdata[68:53])),
    .pos_x          (signed'(in_tdata[84:69])),
    .pos_y          (signed'(in_tdata[100:85])),
    .pos_z          (signed'(in_tdata[116:101])),
    .mean_delay_ps  (mean_delay_r),
    .calc_valid     (calc_valid),
    .calc_item      (calc_item)
  );

  tedq_step_pick #(
    .STEP_COUNT    (STEP_COUNT),
    .SEARCH_RADIUS (SEARCH_RADIUS)
  ) u_step_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .calc_valid (calc_valid),
    .calc_item  (calc_item),
    .res_valid  (res_valid),
    .res_item   (res_item)
  );

  always_comb begin
    out_take       = out_valid_r && out_tready;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = res_item;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.setting_code, out_r.step_index};
  assign out_tuser  = out_r.was_clamped;

  `TEDQ_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r)
  `TEDQ_ASSERT_SAME(a_code_matches_step, out_valid_r, (out_tdata[12:5] == {1'b1, out_tdata[4:0], 2'b00}))
  `TEDQ_ASSERT_NEXT(a_skid_drains, skid_valid_r && out_tready, !skid_valid_r)

endmodule
